/* design/sust_pkg.sv */
// Shared types and codes for the two-set store with union, difference and
// intersection queries. No dependencies; the top level, front end and engine import it.
package sust_pkg;

  // Input item codes for the action field.
  localparam logic [2:0] ACT_INS_A = 3'd0;
  localparam logic [2:0] ACT_INS_B = 3'd1;
  localparam logic [2:0] ACT_UNION = 3'd2;
  localparam logic [2:0] ACT_DIFF  = 3'd3;
  localparam logic [2:0] ACT_ISECT = 3'd4;
  localparam logic [2:0] ACT_CLEAR = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ELEM  = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               has_element;
    logic signed [31:0] element;
    logic               last;
  } out_item_t;

  // Decoded command passed from the front end to the engine.
  typedef enum logic [2:0] {
    OP_INS_A,
    OP_INS_B,
    OP_UNION,
    OP_DIFF,
    OP_ISECT,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_RESULT,
    S_OUTER,
    S_INNER,
    S_EMIT,
    S_FINISH
  } state_e;

endpackage

/* design/set_store_union_diff_intersect.sv */
// Top level of the two-set store: front end, command engine and result queue.
// Depends on sust_pkg, sust_front, sust_back and sust_fifo.
//
//   Channel  Handshake           Payload      Moves
//   input    push / full         in_item_i    one action with its value
//   result   pop / empty         out_item_o   one status or query element
//
// A query walks every outer entry against the other set, one entry at a time.
// Reset empties both sets and both queues; the stored values keep old data.
// A full result queue stalls the engine, and the input queue keeps taking
// items until it fills.
module set_store_union_diff_intersect
  import sust_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int CmdDepth = 2,
  parameter int ResDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  in_item_i,
  output logic      full,
  input  logic      pop,
  output out_item_t out_item_o,
  output logic      empty
);

  cmd_t      cmd;
  logic      cmd_empty, cmd_pop;
  out_item_t res;
  logic      res_push, res_full;
  logic [$bits(out_item_t)-1:0] out_raw;

  sust_front #(
    .CmdDepth(CmdDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  sust_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  sust_fifo #(
    .Width($bits(out_item_t)),
    .Depth(ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_raw),
    .empty_o (empty)
  );

  assign out_item_o = out_item_t'(out_raw);

endmodule

/* design/sust_fifo.sv */
// Small synchronous queue used between the front end, the engine and the
// result port. Depends on nothing but its parameters.
module sust_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/sust_front.sv */
// Front end: decodes input items into commands and queues them for the engine.
// Depends on sust_pkg and sust_fifo.
module sust_front
  import sust_pkg::*;
#(
  parameter int CmdDepth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_item_i,
  output logic     full_o,
  input  logic     cmd_pop_i,
  output cmd_t     cmd_o,
  output logic     cmd_empty_o
);

  cmd_t                 dec_cmd;
  logic                 dec_valid;
  logic [$bits(cmd_t)-1:0] cmd_raw;

  // Unused action codes are accepted and dropped here, so they cause no result.
  always_comb begin
    dec_cmd.value = in_item_i.value;
    dec_cmd.op    = OP_CLEAR;
    dec_valid     = 1'b1;
    case (in_item_i.action)
      ACT_INS_A: dec_cmd.op = OP_INS_A;
      ACT_INS_B: dec_cmd.op = OP_INS_B;
      ACT_UNION: dec_cmd.op = OP_UNION;
      ACT_DIFF:  dec_cmd.op = OP_DIFF;
      ACT_ISECT: dec_cmd.op = OP_ISECT;
      ACT_CLEAR: dec_cmd.op = OP_CLEAR;
      default:   dec_valid  = 1'b0;
    endcase
  end

  sust_fifo #(
    .Width($bits(cmd_t)),
    .Depth(CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && dec_valid),
    .data_i  (dec_cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_raw),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = cmd_t'(cmd_raw);

endmodule

/* design/sust_back.sv */
// Engine: holds both sets and carries out inserts, clears and queries by
// scanning the stored entries one at a time. Depends on sust_pkg.
module sust_back
  import sust_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_empty_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_item_t res_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_e             state_q, state_d;
  op_e                op_q;
  logic [CntW-1:0]    a_cnt_q, b_cnt_q;
  logic [CntW-1:0]    i_q, j_q;
  logic               ph_q;
  logic               pend_valid_q;
  logic signed [31:0] a_vals_q [CAPACITY];
  logic signed [31:0] b_vals_q [CAPACITY];
  logic signed [31:0] operand_q;
  logic signed [31:0] pend_elem_q;
  logic [1:0]         res_status_q;

  logic [IdxW-1:0]    a_idx, b_idx;
  logic signed [31:0] a_rd, b_rd;
  logic signed [31:0] ins_rd, outer_rd, inner_rd;
  logic [CntW-1:0]    ins_cnt, outer_cnt, inner_cnt;
  logic               ins_end, ins_hit, out_end, in_end, in_hit;
  logic               union_a, keep_miss, emit_ok;

  // In the outer state the outer index addresses both sets; otherwise the
  // inner or insert index does.
  assign a_idx = (state_q == S_OUTER) ? i_q[IdxW-1:0] : j_q[IdxW-1:0];
  assign b_idx = a_idx;
  assign a_rd  = a_vals_q[a_idx];
  assign b_rd  = b_vals_q[b_idx];

  assign ins_rd    = (op_q == OP_INS_A) ? a_rd : b_rd;
  assign ins_cnt   = (op_q == OP_INS_A) ? a_cnt_q : b_cnt_q;
  assign outer_rd  = ph_q ? b_rd : a_rd;
  assign outer_cnt = ph_q ? b_cnt_q : a_cnt_q;
  assign inner_rd  = ph_q ? a_rd : b_rd;
  assign inner_cnt = ph_q ? a_cnt_q : b_cnt_q;

  // The end test always wins over a match, as entries past the count are stale.
  assign ins_end   = (j_q == ins_cnt);
  assign ins_hit   = (ins_rd == operand_q);
  assign out_end   = (i_q == outer_cnt);
  assign in_end    = (j_q == inner_cnt);
  assign in_hit    = (inner_rd == operand_q);
  assign union_a   = (op_q == OP_UNION) && !ph_q;
  assign keep_miss = (op_q == OP_DIFF) || (op_q == OP_UNION);
  assign emit_ok   = !pend_valid_q || !res_full_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            OP_INS_A, OP_INS_B: state_d = S_INS;
            OP_CLEAR:           state_d = S_RESULT;
            default:            state_d = S_OUTER;
          endcase
        end
      end
      S_INS: begin
        if (ins_end || ins_hit) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!res_full_i) begin
          state_d = S_IDLE;
        end
      end
      S_OUTER: begin
        if (out_end) begin
          state_d = union_a ? S_OUTER : S_FINISH;
        end else begin
          state_d = union_a ? S_EMIT : S_INNER;
        end
      end
      S_INNER: begin
        if (in_end) begin
          state_d = keep_miss ? S_EMIT : S_OUTER;
        end else if (in_hit) begin
          state_d = (op_q == OP_ISECT) ? S_EMIT : S_OUTER;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          state_d = S_OUTER;
        end
      end
      S_FINISH: begin
        if (!res_full_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs. An emitted element waits in the pending register until the next
  // one or the end of the query shows whether it is the last.
  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    case (state_q)
      S_IDLE: cmd_pop_o = !cmd_empty_i;
      S_RESULT: begin
        res_push_o    = !res_full_i;
        res_o.status  = res_status_q;
        res_o.last    = 1'b1;
      end
      S_EMIT: begin
        res_push_o        = pend_valid_q && !res_full_i;
        res_o.status      = ST_ELEM;
        res_o.has_element = 1'b1;
        res_o.element     = pend_elem_q;
      end
      S_FINISH: begin
        res_push_o        = !res_full_i;
        res_o.status      = ST_ELEM;
        res_o.has_element = pend_valid_q;
        res_o.element     = pend_valid_q ? pend_elem_q : '0;
        res_o.last        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_CLEAR;
      a_cnt_q      <= '0;
      b_cnt_q      <= '0;
      i_q          <= '0;
      j_q          <= '0;
      ph_q         <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (!cmd_empty_i) begin
            op_q         <= cmd_i.op;
            i_q          <= '0;
            j_q          <= '0;
            ph_q         <= 1'b0;
            pend_valid_q <= 1'b0;
            if (cmd_i.op == OP_CLEAR) begin
              a_cnt_q <= '0;
              b_cnt_q <= '0;
            end
          end
        end
        S_INS: begin
          if (ins_end) begin
            if (ins_cnt != CntW'(CAPACITY)) begin
              if (op_q == OP_INS_A) begin
                a_cnt_q <= a_cnt_q + 1'b1;
              end else begin
                b_cnt_q <= b_cnt_q + 1'b1;
              end
            end
          end else if (!ins_hit) begin
            j_q <= j_q + 1'b1;
          end
        end
        S_OUTER: begin
          if (out_end) begin
            if (union_a) begin
              ph_q <= 1'b1;
              i_q  <= '0;
            end
          end else begin
            j_q <= '0;
          end
        end
        S_INNER: begin
          if (in_end) begin
            if (!keep_miss) begin
              i_q <= i_q + 1'b1;
            end
          end else if (in_hit) begin
            if (op_q != OP_ISECT) begin
              i_q <= i_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            pend_valid_q <= 1'b1;
            i_q          <= i_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Set contents and operands carry no reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        operand_q    <= cmd_i.value;
        res_status_q <= ST_ADDED;
      end
      S_INS: begin
        if (ins_end) begin
          if (ins_cnt == CntW'(CAPACITY)) begin
            res_status_q <= ST_FULL;
          end else begin
            res_status_q <= ST_ADDED;
            if (op_q == OP_INS_A) begin
              a_vals_q[a_cnt_q[IdxW-1:0]] <= operand_q;
            end else begin
              b_vals_q[b_cnt_q[IdxW-1:0]] <= operand_q;
            end
          end
        end else if (ins_hit) begin
          res_status_q <= ST_DUP;
        end
      end
      S_OUTER: begin
        if (!out_end) begin
          operand_q <= outer_rd;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          pend_elem_q <= operand_q;
        end
      end
      default: ;
    endcase
  end

endmodule
